// ----- hw/rtl/bpdc_pkg.sv -----
`default_nettype none
package bpdc_pkg;

	// Record type codes
	localparam logic [7:0] TYPE_OPEN      = 8'h05;
	localparam logic [7:0] TYPE_CLOSE     = 8'h06;
	localparam logic [7:0] TYPE_CALL_OPEN = 8'h07;

	// Default stack depth, and the width at which fill counts travel (wide enough for the largest depth)
	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned MAX_FILL_W      = 11;

	// Queue depths between front and back, and in front of the result port
	localparam int unsigned MID_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 2;

	localparam logic [15:0] TALLY_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  param_type;
		logic [15:0] brace_value;
		logic        last_in_tree;
	} bpdc_item_t;

	typedef struct packed {
		logic        overflow_error;
		logic        underflow_error;
		logic        open_mismatch;
		logic        close_mismatch;
		logic        close_warning;
		logic [31:0] matched_open_position;
		logic [31:0] pair_distance;
		logic [6:0]  unmatched_opens;
		logic [15:0] tree_errors;
		logic        tree_done;
	} bpdc_result_t;

	// One stacked open
	typedef struct packed {
		logic [31:0] pos;
		logic [15:0] val;
		logic        call;
	} bpdc_entry_t;

	// Classified record handed from front to back
	typedef struct packed {
		logic                  ovf;
		logic                  unf;
		logic                  matched;
		logic [15:0]           close_val;
		logic [31:0]           pos;
		bpdc_entry_t           entry;
		logic [MAX_FILL_W-1:0] fill;
		logic                  last;
	} bpdc_op_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bpdc_fifo.sv -----
`default_nettype none
module bpdc_fifo #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         put,
	input  wire logic [WIDTH-1:0]             put_data,
	input  wire logic                         take,
	output logic      [WIDTH-1:0]             take_data,
	output logic                              empty,
	output logic                              full,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);
	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_put;
	logic             do_take;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(DEPTH));
	assign count     = count_q;
	assign take_data = data_q[rptr_q];
	assign do_put    = put && !full;
	assign do_take   = take && !empty;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_put) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_take) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_put, do_take})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (do_put) begin
			data_q[wptr_q] <= put_data;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/bpdc_front.sv -----
`default_nettype none
module bpdc_front #(
	parameter int unsigned STACK_DEPTH = bpdc_pkg::STACK_DEPTH_DEF,
	parameter int unsigned MID_DEPTH   = bpdc_pkg::MID_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             push,
	input  wire bpdc_pkg::bpdc_item_t             item,
	output logic                                  full,
	input  wire logic [$clog2(MID_DEPTH+1)-1:0]   mid_count,
	output logic                                  op_valid,
	output bpdc_pkg::bpdc_op_t                    op
);
	import bpdc_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CW = $clog2(MID_DEPTH + 1);

	bpdc_entry_t   stack_mem [STACK_DEPTH];
	logic [FW-1:0] fill_q;
	logic [31:0]   pos_q;
	logic [FW-1:0] fill_dec;
	logic [FW-1:0] fill_after;
	logic [CW:0]   inflight;
	logic          accept;
	logic          is_open;
	logic          is_close;
	logic          push_ok;
	logic          pop_ok;

	logic          valid_s1;
	logic          ovf_s1;
	logic          unf_s1;
	logic          match_s1;
	logic [15:0]   val_s1;
	logic [31:0]   pos_s1;
	logic [FW-1:0] fill_s1;
	logic          last_s1;
	bpdc_entry_t   top_s1;

	// Hold off input while the middle queue cannot take the beats in flight
	assign inflight = {1'b0, mid_count} + {{CW{1'b0}}, valid_s1};
	assign full     = (inflight >= (CW + 1)'(MID_DEPTH));
	assign accept   = push && !full;

	// Classify the record and work out the stack move
	always_comb begin
		is_open    = item.param_type inside {TYPE_OPEN, TYPE_CALL_OPEN};
		is_close   = (item.param_type == TYPE_CLOSE);
		push_ok    = is_open && (fill_q < FW'(STACK_DEPTH));
		pop_ok     = is_close && (fill_q != '0);
		fill_dec   = fill_q - FW'(1);
		fill_after = fill_q;
		if (push_ok) begin
			fill_after = fill_q + FW'(1);
		end else if (pop_ok) begin
			fill_after = fill_dec;
		end
	end

	// Advance fill and position; clear both after the last record of a tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				fill_q <= item.last_in_tree ? '0 : fill_after;
				pos_q  <= item.last_in_tree ? '0 : pos_q + 32'd1;
			end
		end
	end

	// Register the classified beat
	always_ff @(posedge clk) begin
		if (accept) begin
			ovf_s1   <= is_open && !push_ok;
			unf_s1   <= is_close && !pop_ok;
			match_s1 <= pop_ok;
			val_s1   <= item.brace_value;
			pos_s1   <= pos_q;
			fill_s1  <= fill_after;
			last_s1  <= item.last_in_tree;
		end
	end

	// Push opens, read the top entry on a close
	always_ff @(posedge clk) begin
		if (accept && push_ok) begin
			stack_mem[fill_q[AW-1:0]] <= '{pos: pos_q, val: item.brace_value,
				call: (item.param_type == TYPE_CALL_OPEN)};
		end
		if (accept && pop_ok) begin
			top_s1 <= stack_mem[fill_dec[AW-1:0]];
		end
	end

	assign op_valid     = valid_s1;
	assign op.ovf       = ovf_s1;
	assign op.unf       = unf_s1;
	assign op.matched   = match_s1;
	assign op.close_val = val_s1;
	assign op.pos       = pos_s1;
	assign op.entry     = top_s1;
	assign op.fill      = MAX_FILL_W'(fill_s1);
	assign op.last      = last_s1;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STACK_DEPTH))
		else $error("stack fill beyond depth");

	a_tree_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.last_in_tree |=> fill_q == '0 && pos_q == '0)
		else $error("tree state not cleared after last record");

	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> mid_count < CW'(MID_DEPTH))
		else $error("registered beat has no room in middle queue");

endmodule
`default_nettype wire

// ----- hw/rtl/bpdc_back.sv -----
`default_nettype none
module bpdc_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   mid_empty,
	input  wire bpdc_pkg::bpdc_op_t     mid_data,
	output logic                        mid_pop,
	input  wire logic                   out_full,
	output logic                        out_push,
	output bpdc_pkg::bpdc_result_t      out_data
);
	import bpdc_pkg::*;

	logic [15:0] tally_q;
	logic [31:0] pair_dist;
	logic [31:0] dist_m1;
	logic [31:0] open_val;
	logic [31:0] close_val;
	logic        omis;
	logic        cmis;
	logic        warn;
	logic [17:0] sum;
	logic [15:0] tally_sat;

	// Move one beat when the result queue has room
	assign mid_pop  = !mid_empty && !out_full;
	assign out_push = mid_pop;

	// Check the matched pair
	always_comb begin
		pair_dist = mid_data.pos - mid_data.entry.pos;
		dist_m1   = pair_dist - 32'd1;
		open_val  = {16'h0000, mid_data.entry.val};
		close_val = {16'h0000, mid_data.close_val};
		omis      = 1'b0;
		cmis      = 1'b0;
		warn      = 1'b0;
		if (mid_data.matched) begin
			if (mid_data.entry.call) begin
				omis = (open_val != dist_m1);
				warn = (mid_data.close_val != 16'h0000);
			end else begin
				omis = (open_val != pair_dist);
				cmis = (close_val != pair_dist);
			end
		end
	end

	// Add this record's errors and, at the end of a tree, the leftover opens
	always_comb begin
		sum = 18'(tally_q) + 18'(mid_data.ovf) + 18'(mid_data.unf) + 18'(omis) + 18'(cmis);
		if (mid_data.last) begin
			sum = sum + 18'(mid_data.fill);
		end
		tally_sat = (sum > 18'(TALLY_MAX)) ? TALLY_MAX : sum[15:0];
	end

	// Assemble the result beat
	always_comb begin
		out_data.overflow_error        = mid_data.ovf;
		out_data.underflow_error       = mid_data.unf;
		out_data.open_mismatch         = omis;
		out_data.close_mismatch        = cmis;
		out_data.close_warning         = warn;
		out_data.matched_open_position = mid_data.matched ? mid_data.entry.pos : 32'd0;
		out_data.pair_distance         = mid_data.matched ? pair_dist : 32'd0;
		out_data.unmatched_opens       = mid_data.last ? mid_data.fill[6:0] : 7'd0;
		out_data.tree_errors           = tally_sat;
		out_data.tree_done             = mid_data.last;
	end

	// Hold the tally; drop it after the last record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (mid_pop) begin
			tally_q <= mid_data.last ? '0 : tally_sat;
		end
	end

	a_tally_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_data.tree_done |=> tally_q == '0)
		else $error("tally not cleared after tree end");

	a_no_pair_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && (out_data.overflow_error || out_data.underflow_error)
		|-> out_data.pair_distance == 32'd0 && out_data.matched_open_position == 32'd0)
		else $error("pair fields set on a stack fault");

	a_tally_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && !out_data.tree_done |=> tally_q >= $past(tally_q))
		else $error("tally decreased inside a tree");

endmodule
`default_nettype wire

// ----- hw/rtl/brace_pair_distance_checker_unit.sv -----
// Path: a record's result passes the stack read register, the middle queue and the
// result queue before it can be popped.
// Throughput: one record per cycle while full is low; the stack memory port and the single
// check-and-tally step each handle one record a cycle unless the result queue is full.
// Reset: arst_n clears fill, position, tally and all queues at once;
// stack contents are not cleared and only entries below the fill are read.
`default_nettype none
module brace_pair_distance_checker_unit #(
	parameter int unsigned STACK_DEPTH = bpdc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire bpdc_pkg::bpdc_item_t   item,
	output logic                        empty,
	input  wire logic                   pop,
	output bpdc_pkg::bpdc_result_t      result
);
	import bpdc_pkg::*;

	localparam int unsigned MCW = $clog2(MID_DEPTH + 1);
	localparam int unsigned OPW = $bits(bpdc_op_t);
	localparam int unsigned RSW = $bits(bpdc_result_t);

	logic             op_valid;
	bpdc_op_t         op;
	logic [MCW-1:0]   mid_count;
	logic             mid_empty;
	logic             mid_pop;
	logic [OPW-1:0]   mid_raw;
	logic             out_full;
	logic             out_push;
	bpdc_result_t     out_data;
	logic [RSW-1:0]   res_raw;

	// Classify records and run the stack
	bpdc_front #(
		.STACK_DEPTH (STACK_DEPTH),
		.MID_DEPTH   (MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.mid_count (mid_count),
		.op_valid  (op_valid),
		.op        (op)
	);

	// Decouple front from back
	bpdc_fifo #(
		.WIDTH (OPW),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.put       (op_valid),
		.put_data  (op),
		.take      (mid_pop),
		.take_data (mid_raw),
		.empty     (mid_empty),
		.full      (),
		.count     (mid_count)
	);

	// Check pairs and keep the tally
	bpdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (bpdc_op_t'(mid_raw)),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	// Hold results until popped
	bpdc_fifo #(
		.WIDTH (RSW),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.put       (out_push),
		.put_data  (out_data),
		.take      (pop),
		.take_data (res_raw),
		.empty     (empty),
		.full      (out_full),
		.count     ()
	);

	assign result = bpdc_result_t'(res_raw);

endmodule
`default_nettype wire
